// File: src/multichannel_autorange_moving_average_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the auto-ranging moving average core
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_AUTORANGE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define MULTICHANNEL_AUTORANGE_MOVING_AVERAGE_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define MAVG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante
`define MAVG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, defaults and register indexes of the moving average core.
// ----------------------------------------------------------------------------
package mavg_pkg;

  // Default sizing
  localparam int CHANNELS_DEF    = 10;
  localparam int WINDOW_DEF      = 10;
  localparam int SAMPLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int RAW_W    = 10;
  localparam int CFG_W    = 10;
  localparam int OUT_W    = 10;
  localparam int CH_OUT_W = 4;

  // Configuration port
  localparam int                 CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HIGH = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] OUTPUT_LOW_RST  = 10'd0;
  localparam logic [CFG_W-1:0] OUTPUT_HIGH_RST = 10'd128;

endpackage

// File: src/multichannel_autorange_moving_average_core.sv
// Items are processed one at a time, each through the ten-step radix-2 divide of the
// scaling quotient (skipped on a flat range); no new item is taken until the current
// one is emitted, and a result left waiting stalls the input.
// Reset: asynchronous, active low; clears channel position, window slot and window
// sums, loads register reset values, sets low marks to all ones and high marks to
// zero; window entries read as zero until the slot pointer first wraps.
// ----------------------------------------------------------------------------
// multichannel_autorange_moving_average_core
// Round-robin auto-ranging normalizer with a per-channel moving average.
// ----------------------------------------------------------------------------
module multichannel_autorange_moving_average_core #(
  parameter int CHANNELS    = mavg_pkg::CHANNELS_DEF,
  parameter int WINDOW      = mavg_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mavg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mavg_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mavg_pkg::RAW_W-1:0]     raw_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mavg_pkg::CH_OUT_W-1:0]  channel_o,
  output logic [mavg_pkg::CH_OUT_W-1:0]  next_input_o,
  output logic [mavg_pkg::OUT_W-1:0]     filtered_value_o,
  output logic                           frame_end_o
);
  import mavg_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SL_W  = $clog2(WINDOW);
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = OUT_W + $clog2(WINDOW);
  localparam int NUM_W = SB + OUT_W;

  // Reciprocal of the window length: exact floor division for any window sum
  localparam int               AVG_SH  = SUM_W + $clog2(WINDOW);
  localparam int               RCP_W   = SUM_W + 1;
  localparam int               APR_W   = 2 * SUM_W;
  localparam logic [RCP_W-1:0] AVG_RCP = RCP_W'(((1 << AVG_SH) + WINDOW - 1) / WINDOW);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RANGE = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_AVG   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] out_low_q, out_high_q;
  logic [CH_W-1:0]  ch_q;
  logic [SL_W-1:0]  slot_q;
  logic             lap_q;
  logic [SB-1:0]    lo_q  [CHANNELS];
  logic [SB-1:0]    hi_q  [CHANNELS];
  logic [SUM_W-1:0] sum_q [CHANNELS];
  logic [OUT_W-1:0] win_mem [DEPTH];
  logic [OUT_W-1:0] rd_q;
  logic [AW-1:0]    addr_q, addr;

  logic [SB-1:0]    x_q, x_in, lo_new, hi_new;
  logic [SB+RAW_W-1:0] raw_ext;
  logic [SB-1:0]    diff_q, den_q;
  logic [CFG_W-1:0] span, span_q;
  logic             flat_q;
  logic [OUT_W-1:0] s_q;
  logic [SUM_W-1:0] old_val, sum_new;
  logic [NUM_W-1:0] prod;
  logic [APR_W-1:0] avg_prod;
  logic [OUT_W-1:0] avg_q;

  logic             div_start, div_done;
  logic [OUT_W-1:0] div_quot;

  logic             out_valid_q;
  logic             last_ch;
  logic [CH_W-1:0]  next_ch;
  logic [4:0]       nx, conv;

  // Take the sample and its range-mark updates
  assign raw_ext = {{SB{1'b0}}, raw_sample_i};
  assign x_in    = raw_ext[SB-1:0];
  assign lo_new  = (x_q < lo_q[ch_q]) ? x_q : lo_q[ch_q];
  assign hi_new  = (x_q > hi_q[ch_q]) ? x_q : hi_q[ch_q];
  assign span    = (out_high_q >= out_low_q) ? (out_high_q - out_low_q) : '0;
  assign addr    = AW'(ch_q) * AW'(WINDOW) + AW'(slot_q);

  // Window update: drop the oldest value, add the new one
  assign old_val = lap_q ? SUM_W'(rd_q) : '0;
  assign sum_new = sum_q[ch_q] - old_val + SUM_W'(s_q);
  assign prod    = NUM_W'(diff_q) * NUM_W'(span_q);

  // Average the window by multiplying with the reciprocal
  assign avg_prod = APR_W'(sum_q[ch_q]) * APR_W'(AVG_RCP);

  // Feed the divider with the scaling quotient
  assign div_start = (state_q == S_MUL) && !flat_q;

  mavg_div #(
    .NUM_W (NUM_W),
    .DEN_W (SB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Round-robin position and converter input mapping
  assign last_ch = (ch_q == CH_W'(CHANNELS - 1));
  assign next_ch = last_ch ? '0 : ch_q + CH_W'(1);
  assign nx      = 5'(next_ch);
  assign conv    = (nx < 5'd2) ? nx : nx + 5'd2;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_RANGE;
      S_RANGE: state_d = S_MUL;
      S_MUL:   state_d = flat_q ? S_SUM : S_DIV;
      S_DIV:   if (div_done) state_d = S_SUM;
      S_SUM:   state_d = S_AVG;
      S_AVG:   state_d = S_EMIT;
      S_EMIT:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Control state, registers, marks and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_low_q   <= OUTPUT_LOW_RST;
      out_high_q  <= OUTPUT_HIGH_RST;
      ch_q        <= '0;
      slot_q      <= '0;
      lap_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        lo_q[i]  <= '1;
        hi_q[i]  <= '0;
        sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_OUTPUT_LOW:  out_low_q  <= cfg_data_i;
          REG_OUTPUT_HIGH: out_high_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_RANGE) begin
        lo_q[ch_q] <= lo_new;
        hi_q[ch_q] <= hi_new;
      end
      if (state_q == S_SUM) begin
        sum_q[ch_q] <= sum_new;
      end
      // Release the item and advance position and slot
      if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        ch_q        <= next_ch;
        if (last_ch) begin
          if (slot_q == SL_W'(WINDOW - 1)) begin
            slot_q <= '0;
            lap_q  <= 1'b1;
          end else begin
            slot_q <= slot_q + SL_W'(1);
          end
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers and window memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      x_q    <= x_in;
      addr_q <= addr;
      rd_q   <= win_mem[addr];
    end
    if (state_q == S_RANGE) begin
      diff_q <= x_q - lo_new;
      den_q  <= hi_new - lo_new;
      span_q <= span;
      flat_q <= (hi_new <= lo_new) || (span == '0);
    end
    if (state_q == S_MUL && flat_q) begin
      s_q <= out_low_q;
    end
    if (state_q == S_DIV && div_done) begin
      s_q <= OUT_W'(out_low_q + div_quot);
    end
    if (state_q == S_SUM) begin
      win_mem[addr_q] <= s_q;
    end
    if (state_q == S_AVG) begin
      avg_q <= avg_prod[AVG_SH +: OUT_W];
    end
    if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
      channel_o        <= CH_OUT_W'(ch_q);
      next_input_o     <= conv[CH_OUT_W-1:0];
      filtered_value_o <= avg_q;
      frame_end_o      <= last_ch;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller
// guarantees the quotient fits NUM_W-DEN_W bits (num >> QB below den).
// ----------------------------------------------------------------------------
module mavg_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NUM_W-1:0]         num_i,
  input  logic [DEN_W-1:0]         den_i,
  output logic                     done_o,
  output logic [NUM_W-DEN_W-1:0]   quot_o
);
  localparam int QB    = NUM_W - DEN_W;
  localparam int CNT_W = $clog2(QB + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [QB-1:0]    lowq_q, lowq_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial  = {rem_q, lowq_q[QB-1]};
    ge     = (trial >= {1'b0, den_q});
    rem_d  = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    lowq_d = {lowq_q[QB-2:0], ge};
  end

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QB - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Hold the partial remainder and the quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[QB +: DEN_W];
      lowq_q <= num_i[QB-1:0];
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      lowq_q <= lowq_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = lowq_q;

endmodule

// File: src/mavg_chk.sv
// ----------------------------------------------------------------------------
// mavg_chk
// Port-level checks of the moving average core, attached by bind.
// ----------------------------------------------------------------------------
`include "multichannel_autorange_moving_average_core_assert.svh"

module mavg_chk #(
  parameter int CHANNELS = mavg_pkg::CHANNELS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [mavg_pkg::CH_OUT_W-1:0]  channel_o,
  input logic [mavg_pkg::CH_OUT_W-1:0]  next_input_o,
  input logic [mavg_pkg::OUT_W-1:0]     filtered_value_o,
  input logic                           frame_end_o
);
  import mavg_pkg::*;

  // Stalled result holds valid and payload
  `MAVG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(channel_o) && $stable(filtered_value_o) && $stable(next_input_o))

  // Busy after taking an item
  `MAVG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // Frame end marks the last channel only
  `MAVG_ASSERT_SAME(a_frame_end, out_valid_o, frame_end_o == (channel_o == CH_OUT_W'(CHANNELS - 1)))

  // Converter input follows the channel mapping
  `MAVG_ASSERT_SAME(a_next_input, out_valid_o, frame_end_o ? (next_input_o == 4'd0) : (next_input_o == ((channel_o == 4'd0) ? 4'd1 : 4'(channel_o + 4'd3))))

  // Register writes must come only while the block is empty; the core does not enforce it
  `MAVG_ASSERT_SAME(a_cfg_idle, cfg_we_i, in_ready_o && !out_valid_o)

endmodule

bind multichannel_autorange_moving_average_core mavg_chk #(
  .CHANNELS (CHANNELS)
) u_mavg_chk (.*);
